[rtl/rv32i_instruction_decoder_defines.svh]
// assertion macros for the rv32i instruction decoder
// used by rv32i_instruction_decoder.sv, no other dependencies
`ifndef RV32I_INSTRUCTION_DECODER_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_DEFINES_SVH

// property that must hold whenever the block is out of reset
`define RV32ID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RV32ID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rv32id_pkg.sv]
// types and constants of the rv32i instruction decoder
// no dependencies; used by rv32i_instruction_decoder.sv
`timescale 1ns / 1ps

package rv32id_pkg;

  // the halt marker word (addi a0, zero, 255)
  localparam logic [31:0] HaltWord = 32'h0ff00513;

  // funct7 of the alternate forms (sub, sra, srai)
  localparam logic [6:0] F7Base = 7'b0000000;
  localparam logic [6:0] F7Alt  = 7'b0100000;

  // major opcodes
  typedef enum logic [6:0] {
    OpcNull   = 7'b0000000,
    OpcLoad   = 7'b0000011,
    OpcOpImm  = 7'b0010011,
    OpcAuipc  = 7'b0010111,
    OpcStore  = 7'b0100011,
    OpcOp     = 7'b0110011,
    OpcLui    = 7'b0110111,
    OpcBranch = 7'b1100011,
    OpcJalr   = 7'b1100111,
    OpcJal    = 7'b1101111
  } opcode_e;

  // funct3 codes of the alu operations (op and op-imm)
  localparam logic [2:0] F3AddSub = 3'd0;
  localparam logic [2:0] F3Sll    = 3'd1;
  localparam logic [2:0] F3Slt    = 3'd2;
  localparam logic [2:0] F3Sltu   = 3'd3;
  localparam logic [2:0] F3Xor    = 3'd4;
  localparam logic [2:0] F3Srl    = 3'd5;
  localparam logic [2:0] F3Or     = 3'd6;
  localparam logic [2:0] F3And    = 3'd7;

  // funct3 codes of the branches
  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  // funct3 codes of the loads and stores
  localparam logic [2:0] F3Byte  = 3'd0;
  localparam logic [2:0] F3Half  = 3'd1;
  localparam logic [2:0] F3Word  = 3'd2;
  localparam logic [2:0] F3ByteU = 3'd4;
  localparam logic [2:0] F3HalfU = 3'd5;

  // decoded instruction kind
  typedef enum logic [5:0] {
    OpNone  = 6'd0,
    OpLui   = 6'd1,  OpAuipc = 6'd2,  OpJal   = 6'd3,  OpJalr  = 6'd4,
    OpBeq   = 6'd5,  OpBne   = 6'd6,  OpBlt   = 6'd7,  OpBge   = 6'd8,
    OpBltu  = 6'd9,  OpBgeu  = 6'd10,
    OpLb    = 6'd11, OpLh    = 6'd12, OpLw    = 6'd13, OpLbu   = 6'd14,
    OpLhu   = 6'd15,
    OpSb    = 6'd16, OpSh    = 6'd17, OpSw    = 6'd18,
    OpAddi  = 6'd19, OpSlli  = 6'd20, OpSlti  = 6'd21, OpSltiu = 6'd22,
    OpXori  = 6'd23, OpSrli  = 6'd24, OpSrai  = 6'd25, OpOri   = 6'd26,
    OpAndi  = 6'd27,
    OpAdd   = 6'd28, OpSub   = 6'd29, OpSll   = 6'd30, OpSlt   = 6'd31,
    OpSltu  = 6'd32, OpXor   = 6'd33, OpSrl   = 6'd34, OpSra   = 6'd35,
    OpOr    = 6'd36, OpAnd   = 6'd37
  } op_kind_e;

  // instruction format class
  typedef enum logic [2:0] {
    FmtR    = 3'd0,
    FmtI    = 3'd1,
    FmtS    = 3'd2,
    FmtB    = 3'd3,
    FmtU    = 3'd4,
    FmtJ    = 3'd5,
    FmtNone = 3'd6
  } format_e;

  // one decoded result
  typedef struct packed {
    op_kind_e    kind;
    format_e     fmt;
    logic [31:0] imm;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic        no_op;
    logic        halt;
    logic        illegal;
  } dec_result_t;

endpackage

[rtl/rv32i_instruction_decoder.sv]
// rv32i instruction decoder: input register, decode logic, result register
// depends on rv32id_pkg and rv32i_instruction_decoder_defines.svh
`timescale 1ns / 1ps

// Decodes one RV32I instruction word per transfer into instruction kind, format
// class, sign-extended immediate, register fields and no-op, halt and illegal
// flags. Throughput is one word per cycle while no stall holds the stages; a
// word passes from the input register through the decode logic into the result
// register. Each stage moves on whenever the stage after it is empty or moving,
// so a new word can be taken while a finished result still waits for the
// consumer. Illegal encodings give kind zero, format none and a zero immediate.

`include "rv32i_instruction_decoder_defines.svh"

module rv32i_instruction_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  // instruction channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        instr_word_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         op_kind_o,
  output logic [2:0]         format_class_o,
  output logic signed [31:0] immediate_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src_reg_a_o,
  output logic [4:0]         src_reg_b_o,
  output logic               no_op_flag_o,
  output logic               halt_flag_o,
  output logic               illegal_flag_o
);

  logic                     in_valid_q, in_valid_d;
  logic [31:0]              word_q;
  logic                     out_valid_q, out_valid_d;
  rv32id_pkg::dec_result_t  res_q, res_d;
  logic                     out_advance;
  logic                     in_advance;

  // stage handshake
  assign out_advance = !out_valid_q || !out_stall_i;
  assign in_advance  = !in_valid_q || out_advance;
  assign in_stall_o  = !in_advance;

  assign in_valid_d  = in_advance ? in_valid_i : in_valid_q;
  assign out_valid_d = out_advance ? in_valid_q : out_valid_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_advance && in_valid_i) begin
      word_q <= instr_word_i;
    end
    if (out_advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // decode
  always_comb begin
    logic [2:0]          f3;
    logic [6:0]          f7;
    rv32id_pkg::op_kind_e kind;
    rv32id_pkg::format_e  fmt;
    logic                noop;
    logic                bad;

    f3   = word_q[14:12];
    f7   = word_q[31:25];
    kind = rv32id_pkg::OpNone;
    fmt  = rv32id_pkg::FmtNone;
    noop = 1'b0;

    case (rv32id_pkg::opcode_e'(word_q[6:0]))
      rv32id_pkg::OpcNull: begin
        noop = 1'b1;
      end
      rv32id_pkg::OpcLui: begin
        kind = rv32id_pkg::OpLui;
        fmt  = rv32id_pkg::FmtU;
      end
      rv32id_pkg::OpcAuipc: begin
        kind = rv32id_pkg::OpAuipc;
        fmt  = rv32id_pkg::FmtU;
      end
      rv32id_pkg::OpcJal: begin
        kind = rv32id_pkg::OpJal;
        fmt  = rv32id_pkg::FmtJ;
      end
      rv32id_pkg::OpcJalr: begin
        // funct3 of jalr is not checked
        kind = rv32id_pkg::OpJalr;
        fmt  = rv32id_pkg::FmtI;
      end
      rv32id_pkg::OpcBranch: begin
        fmt = rv32id_pkg::FmtB;
        case (f3)
          rv32id_pkg::F3Beq:  kind = rv32id_pkg::OpBeq;
          rv32id_pkg::F3Bne:  kind = rv32id_pkg::OpBne;
          rv32id_pkg::F3Blt:  kind = rv32id_pkg::OpBlt;
          rv32id_pkg::F3Bge:  kind = rv32id_pkg::OpBge;
          rv32id_pkg::F3Bltu: kind = rv32id_pkg::OpBltu;
          rv32id_pkg::F3Bgeu: kind = rv32id_pkg::OpBgeu;
          default:            kind = rv32id_pkg::OpNone;
        endcase
      end
      rv32id_pkg::OpcLoad: begin
        fmt = rv32id_pkg::FmtI;
        case (f3)
          rv32id_pkg::F3Byte:  kind = rv32id_pkg::OpLb;
          rv32id_pkg::F3Half:  kind = rv32id_pkg::OpLh;
          rv32id_pkg::F3Word:  kind = rv32id_pkg::OpLw;
          rv32id_pkg::F3ByteU: kind = rv32id_pkg::OpLbu;
          rv32id_pkg::F3HalfU: kind = rv32id_pkg::OpLhu;
          default:             kind = rv32id_pkg::OpNone;
        endcase
      end
      rv32id_pkg::OpcStore: begin
        fmt = rv32id_pkg::FmtS;
        case (f3)
          rv32id_pkg::F3Byte: kind = rv32id_pkg::OpSb;
          rv32id_pkg::F3Half: kind = rv32id_pkg::OpSh;
          rv32id_pkg::F3Word: kind = rv32id_pkg::OpSw;
          default:            kind = rv32id_pkg::OpNone;
        endcase
      end
      rv32id_pkg::OpcOpImm: begin
        // funct7 is checked only on the right shifts
        fmt = rv32id_pkg::FmtI;
        case (f3)
          rv32id_pkg::F3AddSub: kind = rv32id_pkg::OpAddi;
          rv32id_pkg::F3Sll:    kind = rv32id_pkg::OpSlli;
          rv32id_pkg::F3Slt:    kind = rv32id_pkg::OpSlti;
          rv32id_pkg::F3Sltu:   kind = rv32id_pkg::OpSltiu;
          rv32id_pkg::F3Xor:    kind = rv32id_pkg::OpXori;
          rv32id_pkg::F3Srl: begin
            if (f7 == rv32id_pkg::F7Base) begin
              kind = rv32id_pkg::OpSrli;
            end else if (f7 == rv32id_pkg::F7Alt) begin
              kind = rv32id_pkg::OpSrai;
            end
          end
          rv32id_pkg::F3Or:     kind = rv32id_pkg::OpOri;
          rv32id_pkg::F3And:    kind = rv32id_pkg::OpAndi;
          default:              kind = rv32id_pkg::OpNone;
        endcase
      end
      rv32id_pkg::OpcOp: begin
        // funct7 is checked only on add/sub and the right shifts
        fmt = rv32id_pkg::FmtR;
        case (f3)
          rv32id_pkg::F3AddSub: begin
            if (f7 == rv32id_pkg::F7Base) begin
              kind = rv32id_pkg::OpAdd;
            end else if (f7 == rv32id_pkg::F7Alt) begin
              kind = rv32id_pkg::OpSub;
            end
          end
          rv32id_pkg::F3Sll:  kind = rv32id_pkg::OpSll;
          rv32id_pkg::F3Slt:  kind = rv32id_pkg::OpSlt;
          rv32id_pkg::F3Sltu: kind = rv32id_pkg::OpSltu;
          rv32id_pkg::F3Xor:  kind = rv32id_pkg::OpXor;
          rv32id_pkg::F3Srl: begin
            if (f7 == rv32id_pkg::F7Base) begin
              kind = rv32id_pkg::OpSrl;
            end else if (f7 == rv32id_pkg::F7Alt) begin
              kind = rv32id_pkg::OpSra;
            end
          end
          rv32id_pkg::F3Or:   kind = rv32id_pkg::OpOr;
          rv32id_pkg::F3And:  kind = rv32id_pkg::OpAnd;
          default:            kind = rv32id_pkg::OpNone;
        endcase
      end
      default: begin
        kind = rv32id_pkg::OpNone;
      end
    endcase

    // anything that is not a no-op and found no kind is illegal
    bad = !noop && (kind == rv32id_pkg::OpNone);
    if (bad) begin
      fmt = rv32id_pkg::FmtNone;
    end

    res_d.kind    = kind;
    res_d.fmt     = fmt;
    res_d.rd      = word_q[11:7];
    res_d.rs1     = word_q[19:15];
    res_d.rs2     = word_q[24:20];
    res_d.no_op   = noop;
    res_d.halt    = (word_q == rv32id_pkg::HaltWord);
    res_d.illegal = bad;

    // immediate assembly per format
    case (fmt)
      rv32id_pkg::FmtI: res_d.imm = {{20{word_q[31]}}, word_q[31:20]};
      rv32id_pkg::FmtS: res_d.imm = {{20{word_q[31]}}, word_q[31:25], word_q[11:7]};
      rv32id_pkg::FmtB: res_d.imm = {{19{word_q[31]}}, word_q[31], word_q[7],
                                     word_q[30:25], word_q[11:8], 1'b0};
      rv32id_pkg::FmtU: res_d.imm = {word_q[31:12], 12'h000};
      rv32id_pkg::FmtJ: res_d.imm = {{11{word_q[31]}}, word_q[31], word_q[19:12],
                                     word_q[20], word_q[30:21], 1'b0};
      default:          res_d.imm = 32'h0000_0000;
    endcase
  end

  // result ports
  assign out_valid_o    = out_valid_q;
  assign op_kind_o      = res_q.kind;
  assign format_class_o = res_q.fmt;
  assign immediate_o    = signed'(res_q.imm);
  assign dest_reg_o     = res_q.rd;
  assign src_reg_a_o    = res_q.rs1;
  assign src_reg_b_o    = res_q.rs2;
  assign no_op_flag_o   = res_q.no_op;
  assign halt_flag_o    = res_q.halt;
  assign illegal_flag_o = res_q.illegal;

  // checks
  `RV32ID_ASSERT(a_illegal_clean,
    !(out_valid_o && illegal_flag_o) || (op_kind_o == rv32id_pkg::OpNone &&
    format_class_o == rv32id_pkg::FmtNone && immediate_o == 32'sd0 && !no_op_flag_o),
    "illegal result carries a kind, format or immediate")
  `RV32ID_ASSERT(a_no_imm_r_type,
    !(out_valid_o && (format_class_o == rv32id_pkg::FmtR ||
    format_class_o == rv32id_pkg::FmtNone)) || immediate_o == 32'sd0,
    "immediate not zero for r type or no format")
  `RV32ID_ASSERT_NEXT(a_accept_reaches_stage,
    in_valid_i && !in_stall_o, in_valid_q,
    "accepted word did not reach the input register")

endmodule

[tb/sv/rv32id_decode_checker.sv]
// decode checker for the rv32i instruction decoder: predicts every decode and compares results
// depends on rv32id_pkg for the kind, format and result types
`timescale 1ns / 1ps

module rv32id_decode_checker
  import rv32id_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // instruction channel
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [31:0]        instr_word_i,
  // result channel
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [5:0]         op_kind_i,
  input  logic [2:0]         format_class_i,
  input  logic [31:0]        immediate_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [4:0]         src_reg_a_i,
  input  logic [4:0]         src_reg_b_i,
  input  logic               no_op_flag_i,
  input  logic               halt_flag_i,
  input  logic               illegal_flag_i,
  // status for the testbench top
  output int unsigned        mismatches_o,
  output int unsigned        outstanding_o,
  output int unsigned        checked_o,
  output int unsigned        kinds_hit_o,
  output int unsigned        illegal_seen_o
);

  // one accepted word and the decode it should produce
  typedef struct packed {
    logic [31:0] word;
    dec_result_t res;
  } queued_decode_t;

  queued_decode_t expected_decodes[$];
  logic [37:0]    kinds_seen;

  assign kinds_hit_o = $countones(kinds_seen);

  // decode of one instruction word
  function automatic dec_result_t decode_word(input logic [31:0] w);
    dec_result_t r;
    opcode_e     opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    opc = opcode_e'(w[6:0]);
    f3  = w[14:12];
    f7  = w[31:25];
    r = '0;
    r.kind = OpNone;
    r.fmt  = FmtNone;
    case (opc)
      OpcNull:  r.no_op = 1'b1;
      OpcLui: begin
        r.kind = OpLui;
        r.fmt  = FmtU;
      end
      OpcAuipc: begin
        r.kind = OpAuipc;
        r.fmt  = FmtU;
      end
      OpcJal: begin
        r.kind = OpJal;
        r.fmt  = FmtJ;
      end
      // funct3 of jalr is not looked at
      OpcJalr: begin
        r.kind = OpJalr;
        r.fmt  = FmtI;
      end
      OpcBranch: begin
        r.fmt = FmtB;
        case (f3)
          F3Beq:   r.kind = OpBeq;
          F3Bne:   r.kind = OpBne;
          F3Blt:   r.kind = OpBlt;
          F3Bge:   r.kind = OpBge;
          F3Bltu:  r.kind = OpBltu;
          F3Bgeu:  r.kind = OpBgeu;
          default: r.kind = OpNone;
        endcase
      end
      OpcLoad: begin
        r.fmt = FmtI;
        case (f3)
          F3Byte:  r.kind = OpLb;
          F3Half:  r.kind = OpLh;
          F3Word:  r.kind = OpLw;
          F3ByteU: r.kind = OpLbu;
          F3HalfU: r.kind = OpLhu;
          default: r.kind = OpNone;
        endcase
      end
      OpcStore: begin
        r.fmt = FmtS;
        case (f3)
          F3Byte:  r.kind = OpSb;
          F3Half:  r.kind = OpSh;
          F3Word:  r.kind = OpSw;
          default: r.kind = OpNone;
        endcase
      end
      // shift-immediate right forms need an exact funct7, slli does not
      OpcOpImm: begin
        r.fmt = FmtI;
        case (f3)
          F3AddSub: r.kind = OpAddi;
          F3Sll:    r.kind = OpSlli;
          F3Slt:    r.kind = OpSlti;
          F3Sltu:   r.kind = OpSltiu;
          F3Xor:    r.kind = OpXori;
          F3Srl:    r.kind = (f7 == F7Base) ? OpSrli : (f7 == F7Alt) ? OpSrai : OpNone;
          F3Or:     r.kind = OpOri;
          default:  r.kind = OpAndi;
        endcase
      end
      // only add/sub and srl/sra check funct7
      OpcOp: begin
        r.fmt = FmtR;
        case (f3)
          F3AddSub: r.kind = (f7 == F7Base) ? OpAdd : (f7 == F7Alt) ? OpSub : OpNone;
          F3Sll:    r.kind = OpSll;
          F3Slt:    r.kind = OpSlt;
          F3Sltu:   r.kind = OpSltu;
          F3Xor:    r.kind = OpXor;
          F3Srl:    r.kind = (f7 == F7Base) ? OpSrl : (f7 == F7Alt) ? OpSra : OpNone;
          F3Or:     r.kind = OpOr;
          default:  r.kind = OpAnd;
        endcase
      end
      default: ;
    endcase

    // anything undecodable that is not a no-op is illegal
    if (!r.no_op && r.kind == OpNone) begin
      r.illegal = 1'b1;
      r.fmt     = FmtNone;
    end

    // immediate per format
    case (r.fmt)
      FmtI:    r.imm = {{20{w[31]}}, w[31:20]};
      FmtS:    r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      FmtB:    r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      FmtU:    r.imm = {w[31:12], 12'h000};
      FmtJ:    r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      default: r.imm = '0;
    endcase

    r.rd   = w[11:7];
    r.rs1  = w[19:15];
    r.rs2  = w[24:20];
    r.halt = (w == HaltWord);
    return r;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what, input logic [31:0] word,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns: %s mismatch for word %h: got %h, expected %h",
             $time, what, word, got, want);
    mismatches_o = mismatches_o + 1;
  endtask

  // compare on each result transfer, predict on each instruction transfer
  always @(posedge clk_i or negedge rst_ni) begin
    queued_decode_t head;
    if (!rst_ni) begin
      expected_decodes.delete();
      kinds_seen     = '0;
      mismatches_o   = 0;
      outstanding_o  = 0;
      checked_o      = 0;
      illegal_seen_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_decodes.size() == 0) begin
          report_mismatch("unrequested result", 'x, {26'b0, op_kind_i}, '0);
        end else begin
          head = expected_decodes.pop_front();
          if (op_kind_i !== head.res.kind)
            report_mismatch("op_kind", head.word, 32'(op_kind_i), 32'(head.res.kind));
          if (format_class_i !== head.res.fmt)
            report_mismatch("format_class", head.word, 32'(format_class_i),
                            32'(head.res.fmt));
          if (immediate_i !== head.res.imm)
            report_mismatch("immediate", head.word, immediate_i, head.res.imm);
          if (dest_reg_i !== head.res.rd)
            report_mismatch("dest_reg", head.word, 32'(dest_reg_i), 32'(head.res.rd));
          if (src_reg_a_i !== head.res.rs1)
            report_mismatch("src_reg_a", head.word, 32'(src_reg_a_i), 32'(head.res.rs1));
          if (src_reg_b_i !== head.res.rs2)
            report_mismatch("src_reg_b", head.word, 32'(src_reg_b_i), 32'(head.res.rs2));
          if (no_op_flag_i !== head.res.no_op)
            report_mismatch("no_op_flag", head.word, 32'(no_op_flag_i),
                            32'(head.res.no_op));
          if (halt_flag_i !== head.res.halt)
            report_mismatch("halt_flag", head.word, 32'(halt_flag_i), 32'(head.res.halt));
          if (illegal_flag_i !== head.res.illegal)
            report_mismatch("illegal_flag", head.word, 32'(illegal_flag_i),
                            32'(head.res.illegal));
          checked_o = checked_o + 1;
          kinds_seen[head.res.kind] = 1'b1;
          if (head.res.illegal)
            illegal_seen_o = illegal_seen_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_decodes.push_back({instr_word_i, decode_word(instr_word_i)});
      outstanding_o = expected_decodes.size();
    end
  end

endmodule

[tb/sv/tb_rv32i_instruction_decoder.sv]
// testbench top for the rv32i instruction decoder: clock, reset, stimulus and verdict
// depends on rv32id_pkg, rv32i_instruction_decoder and rv32id_decode_checker
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder;
  import rv32id_pkg::*;

  localparam int unsigned RandomWords = 1150;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [31:0]        instr_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [5:0]         op_kind_o;
  logic [2:0]         format_class_o;
  logic signed [31:0] immediate_o;
  logic [4:0]         dest_reg_o;
  logic [4:0]         src_reg_a_o;
  logic [4:0]         src_reg_b_o;
  logic               no_op_flag_o;
  logic               halt_flag_o;
  logic               illegal_flag_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned kinds_hit;
  int unsigned illegal_seen;

  rv32i_instruction_decoder uut (.*);

  rv32id_decode_checker u_decode_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .instr_word_i   (instr_word_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .op_kind_i      (op_kind_o),
    .format_class_i (format_class_o),
    .immediate_i    (immediate_o),
    .dest_reg_i     (dest_reg_o),
    .src_reg_a_i    (src_reg_a_o),
    .src_reg_b_i    (src_reg_b_o),
    .no_op_flag_i   (no_op_flag_o),
    .halt_flag_i    (halt_flag_o),
    .illegal_flag_i (illegal_flag_o),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .checked_o      (checked),
    .kinds_hit_o    (kinds_hit),
    .illegal_seen_o (illegal_seen)
  );

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_rv32i_instruction_decoder NOT OK");
    $finish;
  end

  // receiver stall: free-running, slow, periodic and heavy stretches in random order
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(negedge clk_i);
        phase = phase + 1;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 9) < 3);
          2:       out_stall_i <= (phase % 3 == 0);
          default: out_stall_i <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // one instruction transfer; valid stays high if the next call follows at once
  task automatic send_word(input logic [31:0] w);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // idle cycles with junk on the payload
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i   <= 1'b0;
      instr_word_i <= $urandom;
    end
  endtask

  // hold off until every decode has come back
  task automatic drain_results();
    idle_cycles(1);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // mostly well-formed words with random content, some broken ones and noise
  function automatic logic [31:0] random_instr();
    logic [31:0]  w;
    int unsigned  pick;
    opcode_e      opc;
    w    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      w = HaltWord;
    end else if (pick < 7) begin
      w[6:0] = OpcNull;
    end else if (pick < 15) begin
      // raw noise, mostly unknown opcodes
    end else begin
      case ($urandom_range(0, 9))
        0:       opc = OpcLoad;
        1:       opc = OpcOpImm;
        2:       opc = OpcAuipc;
        3:       opc = OpcStore;
        4:       opc = OpcOp;
        5:       opc = OpcLui;
        6:       opc = OpcBranch;
        7:       opc = OpcJalr;
        8:       opc = OpcJal;
        default: opc = OpcOpImm;
      endcase
      w[6:0] = opc;
      // a share keeps random funct fields, so broken encodings turn up
      if (pick >= 30) begin
        case (opc)
          OpcBranch: while (w[14:12] inside {3'd2, 3'd3}) w[14:12] = 3'($urandom);
          OpcLoad:   while (w[14:12] inside {3'd3, 3'd6, 3'd7}) w[14:12] = 3'($urandom);
          OpcStore:  w[14:12] = 3'($urandom_range(0, 2));
          OpcOpImm: begin
            if (w[14:12] == F3Srl)
              w[31:25] = $urandom_range(0, 1) ? F7Alt : F7Base;
          end
          OpcOp: begin
            if (w[14:12] == F3AddSub || w[14:12] == F3Srl)
              w[31:25] = $urandom_range(0, 1) ? F7Alt : F7Base;
            else if ($urandom_range(0, 1))
              w[31:25] = F7Base;
          end
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  // stimulus
  initial begin
    logic [31:0]  corner_words[$];
    int unsigned  sent;
    int unsigned  burst;
    int unsigned  n_corner;
    sent = 0;

    // reset, released on a falling edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner words: no-op, halt, immediate extremes, broken and lenient encodings
    corner_words = '{
      32'h0000_0000,
      {25'h1FF_FFFF, OpcNull},
      HaltWord,
      {20'hFFFFF, 5'd31, OpcLui},
      {20'h80000, 5'd0, OpcAuipc},
      {20'hFFFFF, 5'd1, OpcJal},
      {20'h7FFFF, 5'd31, OpcJal},
      {12'h800, 5'd31, 3'd7, 5'd1, OpcJalr},
      {7'h7F, 5'd31, 5'd31, F3Beq, 5'h1F, OpcBranch},
      {7'h3F, 5'd0, 5'd0, F3Bgeu, 5'h1E, OpcBranch},
      {7'h00, 5'd1, 5'd2, 3'd2, 5'h00, OpcBranch},
      {12'h7FF, 5'd3, F3Word, 5'd4, OpcLoad},
      {12'h000, 5'd3, 3'd6, 5'd4, OpcLoad},
      {7'h40, 5'd9, 5'd8, F3Word, 5'h00, OpcStore},
      {7'h3F, 5'd9, 5'd8, 3'd3, 5'h1F, OpcStore},
      {F7Alt, 5'd31, 5'd1, F3Srl, 5'd2, OpcOpImm},
      {7'h01, 5'd31, 5'd1, F3Srl, 5'd2, OpcOpImm},
      {7'h7F, 5'd31, 5'd1, F3Sll, 5'd2, OpcOpImm},
      {12'hFFF, 5'd31, F3AddSub, 5'd31, OpcOpImm},
      {F7Alt, 5'd7, 5'd6, F3AddSub, 5'd5, OpcOp},
      {7'h40, 5'd7, 5'd6, F3AddSub, 5'd5, OpcOp},
      {F7Alt, 5'd7, 5'd6, F3Srl, 5'd5, OpcOp},
      {7'h7F, 5'd7, 5'd6, F3Xor, 5'd5, OpcOp},
      32'hFFFF_FFFF,
      {25'h0, 7'h01}
    };
    n_corner = corner_words.size();
    foreach (corner_words[i]) send_word(corner_words[i]);
    drain_results();

    // random bursts with gaps, and one more full drain half way
    while (sent < RandomWords) begin
      burst = $urandom_range(1, 24);
      for (int unsigned i = 0; i < burst && sent < RandomWords; i++) begin
        send_word(random_instr());
        sent = sent + 1;
        if (sent == RandomWords / 2)
          drain_results();
      end
      if ($urandom_range(0, 9) == 0)
        idle_cycles($urandom_range(10, 30));
      else
        idle_cycles($urandom_range(0, 3));
    end

    // let the pipeline settle once everything is back
    drain_results();
    repeat (4) @(negedge clk_i);

    $display("covered %0d directed and %0d random instruction words, %0d results checked",
             n_corner, sent, checked);
    $display("%0d of 38 kind codes seen, %0d illegal encodings, stalls on both channels",
             kinds_hit, illegal_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_rv32i_instruction_decoder OK");
    end else begin
      $display("tb_rv32i_instruction_decoder NOT OK");
    end
    $finish;
  end

endmodule
